// ===== rtl/swad_pkg.sv =====
// Shared constants, item codes and pipeline types for the sliding-window
// anagram detector. No dependencies; swad_front, swad_tally, swad_outq and the top level import this.
`default_nettype none

package swad_pkg;

  // Sizing
  localparam int MAX_PATTERN   = 64;
  localparam int ALPHABET_SIZE = 26;

  // Field widths fixed by the stream format
  localparam int OP_W       = 2;
  localparam int LETTER_W   = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // Derived widths
  localparam int HIST_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int BIN_AW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  // counts hold window-minus-pattern differences in [-MAX, +MAX], kept modulo 2^CNT_W
  localparam int CNT_W   = $clog2(MAX_PATTERN + 1) + 1;
  localparam int TALLY_W = $clog2(ALPHABET_SIZE + 1);

  // Result queue (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_END     = 2'd3
  } op_t;

  // Item leaving the front stage (window bookkeeping already decided)
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [LETTER_W-1:0] letter;
    logic                pat_add;    // pattern letter counted
    logic                add_en;     // text letter enters a bin
    logic                evict;      // oldest ring letter leaves the window
    logic                empty_pat;  // pattern length is zero
    logic                overflow;   // sticky overflow flag after this item
  } front_t;

  // One result beat
  typedef struct packed {
    logic overflow;
    logic is_end;
    logic found;
    logic match;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/swad_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read
// (read-old on a same-address collision). No dependencies.
`default_nettype none

module swad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/swad_front.sv =====
// Front stage: decodes each accepted beat, keeps pattern length, window fill,
// ring pointer and overflow flag, and owns the letter history ring.
// Depends on swad_pkg and swad_ram.
`default_nettype none

module swad_front import swad_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [OP_W-1:0]     op,
  input  logic [LETTER_W-1:0] letter,
  output front_t              stage,
  output logic [LETTER_W-1:0] old_letter
);

  logic [LEN_W-1:0]   plen, plen_next;
  logic [LEN_W-1:0]   fill, fill_next;
  logic [HIST_AW-1:0] ptr, ptr_next;
  logic               ovf, ovf_next;
  logic [LEN_W-1:0]   slot_wide;
  logic [HIST_AW-1:0] old_slot;
  logic               letter_ok;
  logic               hist_we;
  logic               pat_add, add_en, evict;
  op_t                op_code;
  front_t             stage_next;

  // Slot of the letter leaving the window: ptr - plen modulo the ring size
  always_comb begin
    if (LEN_W'(ptr) >= plen) begin
      slot_wide = LEN_W'(ptr) - plen;
    end else begin
      slot_wide = LEN_W'(ptr) + LEN_W'(MAX_PATTERN) - plen;
    end
    old_slot = HIST_AW'(slot_wide);
  end

  // Window bookkeeping per item
  always_comb begin
    op_code   = op_t'(op);
    letter_ok = (letter < ALPHABET_SIZE);
    plen_next = plen;
    fill_next = fill;
    ptr_next  = ptr;
    ovf_next  = ovf;
    hist_we   = 1'b0;
    pat_add   = 1'b0;
    add_en    = 1'b0;
    evict     = 1'b0;
    if (accept) begin
      unique case (op_code)
        OP_START: begin
          plen_next = '0;
          fill_next = '0;
          ptr_next  = '0;
          ovf_next  = 1'b0;
        end
        OP_PATTERN: begin
          // pattern letters only count before any text arrived
          if (fill == '0 && letter_ok) begin
            if (plen >= LEN_W'(MAX_PATTERN)) begin
              ovf_next = 1'b1;
            end else begin
              plen_next = plen + LEN_W'(1);
              pat_add   = 1'b1;
            end
          end
        end
        OP_TEXT: begin
          if (plen != '0) begin
            hist_we = 1'b1;
            add_en  = letter_ok;
            if (fill >= plen) begin
              evict = 1'b1;
            end else begin
              fill_next = fill + LEN_W'(1);
            end
            ptr_next = (ptr == HIST_AW'(MAX_PATTERN - 1)) ? '0 : ptr + HIST_AW'(1);
          end
        end
        OP_END: begin
        end
      endcase
    end
  end

  // Item handed to the count stage
  always_comb begin
    stage_next.valid     = accept;
    stage_next.op        = op_code;
    stage_next.letter    = letter;
    stage_next.pat_add   = pat_add;
    stage_next.add_en    = add_en;
    stage_next.evict     = evict;
    stage_next.empty_pat = (plen_next == '0);
    stage_next.overflow  = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen  <= '0;
      fill  <= '0;
      ptr   <= '0;
      ovf   <= 1'b0;
      stage <= '0;
    end else begin
      plen  <= plen_next;
      fill  <= fill_next;
      ptr   <= ptr_next;
      ovf   <= ovf_next;
      stage <= stage_next;
    end
  end

  // Letter history ring; read and write share the accept edge (read-old)
  swad_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (ptr),
    .wdata (letter),
    .raddr (old_slot),
    .rdata (old_letter)
  );

endmodule

`default_nettype wire

// ===== rtl/swad_tally.sv =====
// Count stage: two count memories (window adds, pattern plus window removals),
// read-modify-write with one-deep forwarding, and a running tally of bins
// whose difference is nonzero. Depends on swad_pkg and swad_ram.
`default_nettype none

module swad_tally import swad_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  front_t              stage,
  input  logic [LETTER_W-1:0] old_letter,
  output logic                busy,
  output logic                res_valid,
  output res_t                res
);

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              up_en;
    logic              dn_en;
    logic [BIN_AW-1:0] bin_a;
    logic [BIN_AW-1:0] bin_b;
    logic              empty_pat;
    logic              overflow;
  } s2_t;

  typedef struct packed {
    logic              en;
    logic [BIN_AW-1:0] addr;
    logic [CNT_W-1:0]  data;
  } wr_t;

  s2_t                    s2, s2_next;
  wr_t                    up_w, dn_w;
  logic                   sub_en;
  logic [ALPHABET_SIZE-1:0] up_vld, dn_vld;
  logic [CNT_W-1:0]       up_qa, up_qb, dn_qa, dn_qb;
  logic [CNT_W-1:0]       ua, ub, da, db;
  logic [CNT_W-1:0]       d_a, d_b;
  logic [CNT_W-1:0]       up_wdata, dn_wdata;
  logic                   up_we, dn_we;
  logic                   a_was, a_now, b_was, b_now;
  logic [1:0]             inc, dec;
  logic [TALLY_W-1:0]     tally, tally_next;
  logic                   found, found_next;
  logic                   is_start, match;

  // Forwarded value, else stored value, else zero for a bin untouched since start
  function automatic logic [CNT_W-1:0] pick(input wr_t w, input logic [BIN_AW-1:0] addr,
                                            input logic vld, input logic [CNT_W-1:0] q);
    if (w.en && w.addr == addr) begin
      pick = w.data;
    end else if (vld) begin
      pick = q;
    end else begin
      pick = '0;
    end
  endfunction

  // Stage 1: choose the bins to touch, issue memory reads
  always_comb begin
    sub_en          = stage.evict && (old_letter < ALPHABET_SIZE);
    s2_next.valid   = stage.valid;
    s2_next.op      = stage.op;
    s2_next.up_en   = stage.add_en;
    s2_next.dn_en   = stage.pat_add || sub_en;
    s2_next.bin_a   = stage.add_en ? BIN_AW'(stage.letter) : '0;
    if (stage.pat_add) begin
      s2_next.bin_b = BIN_AW'(stage.letter);
    end else if (sub_en) begin
      s2_next.bin_b = BIN_AW'(old_letter);
    end else begin
      s2_next.bin_b = '0;
    end
    s2_next.empty_pat = stage.empty_pat;
    s2_next.overflow  = stage.overflow;
  end

  // Stage 2: differences before the update and the tally change
  always_comb begin
    ua  = pick(up_w, s2.bin_a, up_vld[s2.bin_a], up_qa);
    da  = pick(dn_w, s2.bin_a, dn_vld[s2.bin_a], dn_qa);
    ub  = pick(up_w, s2.bin_b, up_vld[s2.bin_b], up_qb);
    db  = pick(dn_w, s2.bin_b, dn_vld[s2.bin_b], dn_qb);
    d_a = ua - da;
    d_b = ub - db;
    a_was = (d_a != '0);
    a_now = ((d_a + CNT_W'(1)) != '0);
    b_was = (d_b != '0);
    b_now = ((d_b - CNT_W'(1)) != '0);
    up_we    = s2.valid && s2.up_en;
    dn_we    = s2.valid && s2.dn_en;
    up_wdata = ua + CNT_W'(1);
    dn_wdata = db + CNT_W'(1);
    // letter entering equals letter leaving: difference unchanged
    if (up_we && dn_we && s2.bin_a == s2.bin_b) begin
      inc = 2'd0;
      dec = 2'd0;
    end else begin
      inc = {1'b0, up_we && !a_was && a_now} + {1'b0, dn_we && !b_was && b_now};
      dec = {1'b0, up_we && a_was && !a_now} + {1'b0, dn_we && b_was && !b_now};
    end
    tally_next = tally + TALLY_W'(inc) - TALLY_W'(dec);
    match      = (tally_next == '0);
    is_start   = s2.valid && (s2.op == OP_START);
    res_valid  = s2.valid && (s2.op == OP_TEXT || s2.op == OP_END);
    found_next = found || match;
  end

  // Result beat
  always_comb begin
    res.match    = match;
    res.found    = found_next || s2.empty_pat;
    res.is_end   = (s2.op == OP_END);
    res.overflow = s2.overflow;
    busy         = s2.valid;
  end

  // Pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= s2_next;
    end
  end

  // Tally, found flag, bin valid bits and forwarding registers
  always_ff @(posedge clk) begin
    // forwarded payload, qualified by the enables below
    up_w.addr <= s2.bin_a;
    up_w.data <= up_wdata;
    dn_w.addr <= s2.bin_b;
    dn_w.data <= dn_wdata;
    if (rst || is_start) begin
      tally   <= '0;
      found   <= 1'b0;
      up_vld  <= '0;
      dn_vld  <= '0;
      up_w.en <= 1'b0;
      dn_w.en <= 1'b0;
    end else begin
      if (s2.valid) begin
        tally <= tally_next;
      end
      if (res_valid) begin
        found <= found_next;
      end
      if (up_we) begin
        up_vld[s2.bin_a] <= 1'b1;
      end
      if (dn_we) begin
        dn_vld[s2.bin_b] <= 1'b1;
      end
      up_w.en <= up_we;
      dn_w.en <= dn_we;
    end
  end

  // Window-add counts, duplicated for two read addresses
  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET_SIZE)) u_up_a (
    .clk(clk), .we(up_we), .waddr(s2.bin_a), .wdata(up_wdata),
    .raddr(s2_next.bin_a), .rdata(up_qa)
  );
  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET_SIZE)) u_up_b (
    .clk(clk), .we(up_we), .waddr(s2.bin_a), .wdata(up_wdata),
    .raddr(s2_next.bin_b), .rdata(up_qb)
  );

  // Pattern-plus-removal counts, duplicated for two read addresses
  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET_SIZE)) u_dn_a (
    .clk(clk), .we(dn_we), .waddr(s2.bin_b), .wdata(dn_wdata),
    .raddr(s2_next.bin_a), .rdata(dn_qa)
  );
  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET_SIZE)) u_dn_b (
    .clk(clk), .we(dn_we), .waddr(s2.bin_b), .wdata(dn_wdata),
    .raddr(s2_next.bin_b), .rdata(dn_qb)
  );

endmodule

`default_nettype wire

// ===== rtl/swad_outq.sv =====
// Small result queue between the count stage and the output stream.
// Depends on swad_pkg.
`default_nettype none

module swad_outq import swad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t              push_data,
  input  logic              ready,
  output logic              valid,
  output res_t              head,
  output logic [QCNT_W-1:0] count
);

  res_t            entries [QUEUE_DEPTH];
  logic [QA_W-1:0] wr, rd;
  logic            pop;

  assign valid = (count != '0);
  assign head  = entries[rd];
  assign pop   = valid && ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= wr + QA_W'(1);
      end
      if (pop) begin
        rd <= rd + QA_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_anagram_detect_core.sv =====
// Sliding-window anagram detector, top level. Depends on swad_pkg, swad_front,
// swad_tally, swad_outq (and swad_ram through them).
//
// Send a start beat, then pattern letters, then text letters, then an end
// beat. Each text beat and the end beat return one result beat: window_match
// says the last pattern-length text letters are a permutation of the pattern,
// found is sticky since start (or the pattern is empty), pattern_overflow
// flags pattern letters dropped past 64, and tlast marks the answer to the end
// beat. Start and pattern beats return nothing. The block takes one beat per
// clock while s_tready is high; a result goes through the front stage register
// and history-ring read, the count-stage register and read-modify-write of the
// letter count memories, then the result queue. s_tready drops only when the
// four-entry queue plus the beats in the pipeline would fill it, so with m_tready
// held high the input never stalls. No clearing pass is needed after reset or start.
`default_nettype none

module sliding_window_anagram_detect_core import swad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [4:0] letter, rest zero
  input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] window_match, [1] found, [2] pattern_overflow
  output logic                  m_tlast    // end_of_text
);

  logic                accept;
  front_t              stage;
  logic [LETTER_W-1:0] old_letter;
  logic                busy2;
  logic                res_valid;
  res_t                res;
  res_t                head;
  logic [QCNT_W-1:0]   q_count;
  logic [QCNT_W:0]     occupancy;

  // Accept only while every beat in flight is sure of a queue slot
  assign occupancy = {1'b0, q_count} + (QCNT_W + 1)'(stage.valid) + (QCNT_W + 1)'(busy2);
  assign s_tready  = (occupancy < (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept    = s_tvalid && s_tready;

  swad_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (s_tuser),
    .letter     (s_tdata[LETTER_W-1:0]),
    .stage      (stage),
    .old_letter (old_letter)
  );

  swad_tally u_tally (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .old_letter (old_letter),
    .busy       (busy2),
    .res_valid  (res_valid),
    .res        (res)
  );

  swad_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .ready     (m_tready),
    .valid     (m_tvalid),
    .head      (head),
    .count     (q_count)
  );

  // Output beat packing
  assign m_tdata = OUT_DATA_W'({head.overflow, head.found, head.match});
  assign m_tlast = head.is_end;

endmodule

`default_nettype wire

// ===== tb/swad_checker.sv =====
// Scoreboard for the sliding-window anagram detector: watches both stream
// ports, keeps its own letter histograms and history ring, and compares every
// result beat with the predicted one. Depends on swad_pkg.
`default_nettype none

module swad_checker import swad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [4:0] letter
  input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // [0] window_match, [1] found, [2] pattern_overflow
  input  logic                  m_tlast,   // end_of_text
  output int                    fail_count,
  output int                    pending,
  output int                    result_count,
  output int                    match_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic window_match;
    logic found;
    logic end_of_text;
    logic pattern_overflow;
  } verdict_t;

  // Shadow of the detector state
  int                  pat_hist [ALPHABET_SIZE];
  int                  win_hist [ALPHABET_SIZE];
  logic [LETTER_W-1:0] ring [MAX_PATTERN];
  int                  pat_len;
  int                  win_fill;
  int                  ring_ptr;
  logic                found_seen;
  logic                overflow_seen;

  verdict_t            expected_verdicts [$];
  int                  errors      = 0;
  int                  results     = 0;
  int                  match_total = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_search();
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      pat_hist[k] = 0;
      win_hist[k] = 0;
    end
    for (int k = 0; k < MAX_PATTERN; k++) ring[k] = '0;
    pat_len       = 0;
    win_fill      = 0;
    ring_ptr      = 0;
    found_seen    = 1'b0;
    overflow_seen = 1'b0;
  endtask

  // Advance the shadow state by one input beat; text and end beats queue a verdict
  task automatic search_step(input op_t op, input logic [LETTER_W-1:0] ltr);
    verdict_t v;
    int       oldest;
    logic     same;
    case (op)
      OP_START: begin
        clear_search();
      end
      OP_PATTERN: begin
        // pattern grows only before the first text letter, and only with real letters
        if (win_fill == 0 && ltr < ALPHABET_SIZE) begin
          if (pat_len >= MAX_PATTERN) overflow_seen = 1'b1;
          else begin
            pat_hist[ltr]++;
            pat_len++;
          end
        end
      end
      default: begin
        if (op == OP_TEXT && pat_len != 0) begin
          // full window: the letter pattern-length slots back drops out
          if (win_fill >= pat_len) begin
            oldest = int'(ring[(ring_ptr + MAX_PATTERN - pat_len) % MAX_PATTERN]);
            if (oldest < ALPHABET_SIZE && win_hist[oldest] > 0) win_hist[oldest]--;
          end else begin
            win_fill++;
          end
          if (ltr < ALPHABET_SIZE) win_hist[ltr]++;
          ring[ring_ptr] = ltr;
          ring_ptr = (ring_ptr + 1) % MAX_PATTERN;
        end
        same = 1'b1;
        for (int k = 0; k < ALPHABET_SIZE; k++)
          if (pat_hist[k] != win_hist[k]) same = 1'b0;
        if (same) found_seen = 1'b1;
        v.window_match     = same;
        v.found            = found_seen || (pat_len == 0);
        v.end_of_text      = (op == OP_END);
        v.pattern_overflow = overflow_seen;
        expected_verdicts = {expected_verdicts, v};
      end
    endcase
  endtask

  // Compare the output beat first so a beat accepted at the same edge cannot pair with it
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      clear_search();
      expected_verdicts.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results++;
        if (m_tdata[0]) match_total++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result beat arrived with no verdict pending");
        end else begin
          want = expected_verdicts.pop_front();
          if (m_tdata[0] !== want.window_match)
            report_mismatch($sformatf("window_match got %b want %b",
                                      m_tdata[0], want.window_match));
          if (m_tdata[1] !== want.found)
            report_mismatch($sformatf("found got %b want %b", m_tdata[1], want.found));
          if (m_tlast !== want.end_of_text)
            report_mismatch($sformatf("end_of_text got %b want %b",
                                      m_tlast, want.end_of_text));
          if (m_tdata[2] !== want.pattern_overflow)
            report_mismatch($sformatf("pattern_overflow got %b want %b",
                                      m_tdata[2], want.pattern_overflow));
        end
      end
      if (s_tvalid && s_tready)
        search_step(op_t'(s_tuser), s_tdata[LETTER_W-1:0]);
    end
    fail_count   <= errors;
    pending      <= expected_verdicts.size();
    result_count <= results;
    match_count  <= match_total;
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the anagram detector regression: clock, reset, beat source and result
// sink with random gaps, watchdog and verdict. Depends on swad_pkg, swad_checker
// and the sliding_window_anagram_detect_core RTL.
`default_nettype none

module testbench;
  import swad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;           // [4:0] letter
  logic [OP_W-1:0]       s_tuser = OP_START;     // [1:0] operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;                // [0] match, [1] found, [2] overflow
  logic                  m_tlast;                // end_of_text

  int   fail_count;
  int   pending;
  int   result_count;
  int   match_count;
  int   beats_sent = 0;
  int   idle_cycles = 0;
  logic no_gaps = 1'b0;
  logic hold_done = 1'b0;

  always #5 clk = ~clk;

  sliding_window_anagram_detect_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  swad_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .match_count  (match_count)
  );

  // Mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(input op_t op, input logic [LETTER_W-1:0] ltr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W-LETTER_W){1'b0}}, ltr};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // Stop offering until every predicted result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Watchdog: cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("sliding_window_anagram_detect_core regression: fail");
      $finish;
    end
  end

  // Result sink: bursts of ready, random gaps, one long hold-off
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!hold_done && result_count >= 120) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Beat source and verdict
  initial begin
    int seq;
    int base;
    int r;
    int pat_len;
    int txt_len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pattern answers found, foreign pattern letter keeps it empty
    send_beat(OP_START, 5'd0);
    send_beat(OP_END, 5'd31);
    send_beat(OP_TEXT, 5'd25);
    send_beat(OP_PATTERN, 5'd31);
    send_beat(OP_END, 5'd0);
    // pattern "az": match, miss, foreign text letter, late pattern letter
    send_beat(OP_START, 5'd31);
    send_beat(OP_PATTERN, 5'd0);
    send_beat(OP_PATTERN, 5'd25);
    send_beat(OP_TEXT, 5'd25);
    send_beat(OP_TEXT, 5'd0);
    send_beat(OP_TEXT, 5'd15);
    send_beat(OP_TEXT, 5'd31);
    send_beat(OP_PATTERN, 5'd0);
    send_beat(OP_TEXT, 5'd0);
    send_beat(OP_TEXT, 5'd25);
    send_beat(OP_END, 5'd7);
    wait_drained();

    // random searches over a three-letter alphabet so windows match often
    seq = 0;
    while (beats_sent < 390) begin
      base = $urandom_range(0, ALPHABET_SIZE - 3);
      r    = $urandom_range(0, 99);
      if (seq == 3 || r < 3) pat_len = $urandom_range(MAX_PATTERN, MAX_PATTERN + 6);
      else if (r < 8) pat_len = 0;
      else pat_len = $urandom_range(1, 5);
      no_gaps = (seq % 4 == 2);

      if (seq < 2 || $urandom_range(0, 9) != 0)
        send_beat(OP_START, 5'($urandom_range(0, 31)));
      for (int i = 0; i < pat_len; i++) begin
        if ($urandom_range(0, 29) == 0) send_beat(OP_PATTERN, 5'($urandom_range(0, 31)));
        else send_beat(OP_PATTERN, 5'(base + $urandom_range(0, 2)));
      end

      txt_len = (pat_len == 0) ? $urandom_range(1, 4) : pat_len + $urandom_range(0, 10);
      for (int i = 0; i < txt_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 84) send_beat(OP_TEXT, 5'(base + $urandom_range(0, 2)));
        else if (r < 94) send_beat(OP_TEXT, 5'($urandom_range(0, 31)));
        else if (r < 97) send_beat(OP_PATTERN, 5'($urandom_range(0, 31)));
        else send_beat(OP_END, 5'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 9) != 0) send_beat(OP_END, 5'($urandom_range(0, 31)));
      if (seq == 6) wait_drained();
      seq++;
    end

    no_gaps = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d input beats in %0d random searches (empty and overflowing patterns",
             beats_sent, seq);
    $display("included), %0d result beats, %0d window matches", result_count, match_count);
    if (fail_count == 0 && pending == 0) begin
      $display("sliding_window_anagram_detect_core regression: pass");
    end else begin
      $display("sliding_window_anagram_detect_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/swad_pkg.sv
rtl/swad_ram.sv
rtl/swad_front.sv
rtl/swad_tally.sv
rtl/swad_outq.sv
rtl/sliding_window_anagram_detect_core.sv
tb/swad_checker.sv
tb/testbench.sv
